### rtl/gcrf_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// gcrf_pkg
// Shared types and constants of the gate censor run filter.
// -----------------------------------------------------------------------------
package gcrf_pkg;

  // Default block sizes
  localparam int NUM_FIELDS_DEF  = 4;
  localparam int MAX_GATES_DEF   = 4096;
  localparam int VALUE_WIDTH_DEF = 16;

  // Test fields that have limit registers
  localparam int HW_FIELDS = 4;

  // Fixed register and descriptor widths
  localparam int LIMIT_W     = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int MIN_RUN_W   = 13;
  localparam int RUN_START_W = 12;
  localparam int RUN_LEN_W   = 13;
  localparam int OUT_TDATA_W = 32;

  // Output queue depth; a gate may push two descriptors
  localparam int OUTQ_DEPTH = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMITS_0  = 3'd0,
    REG_LIMITS_1  = 3'd1,
    REG_LIMITS_2  = 3'd2,
    REG_LIMITS_3  = 3'd3,
    REG_AND_MASK  = 3'd4,
    REG_ACT_MASK  = 3'd5,
    REG_MIN_RUN   = 3'd6,
    REG_CENSOR_EN = 3'd7
  } cfg_reg_e;

  // Per-field findings of one lane
  typedef struct packed {
    logic or_used;   // active OR field, present
    logic or_miss;   // active OR field, absent
    logic or_hit;    // active OR field, present and within limits
    logic and_fail;  // active AND field, present and outside limits
  } lane_flags_t;

  // One run descriptor
  typedef struct packed {
    logic                   ray_end;
    logic                   censored;
    logic [RUN_LEN_W-1:0]   run_length;
    logic [RUN_START_W-1:0] run_start;
  } desc_t;

  // Descriptors produced by one gate, slot 0 first
  typedef struct packed {
    logic  push0;
    logic  push1;
    desc_t d0;
    desc_t d1;
  } emit_t;

endpackage : gcrf_pkg
`default_nettype wire

### rtl/gcrf_lane.sv
`default_nettype none
// -----------------------------------------------------------------------------
// gcrf_lane
// Limit test of one test field: signed inclusive compare and role flags.
// -----------------------------------------------------------------------------
module gcrf_lane #(
  parameter int VALUE_WIDTH = gcrf_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic signed [VALUE_WIDTH-1:0]         value_i,
  input  wire logic [gcrf_pkg::CFG_DATA_W-1:0]       limits_i,
  input  wire logic                                  active_i,
  input  wire logic                                  and_mode_i,
  input  wire logic                                  present_i,
  output      gcrf_pkg::lane_flags_t                 flags_o
);
  import gcrf_pkg::*;

  localparam int CW = (VALUE_WIDTH > LIMIT_W) ? VALUE_WIDTH : LIMIT_W;

  logic signed [CW-1:0]      val_x;
  logic signed [CW-1:0]      lo_x;
  logic signed [CW-1:0]      hi_x;
  logic signed [LIMIT_W-1:0] lo;
  logic signed [LIMIT_W-1:0] hi;
  logic                      in_win;

  // Min in the upper half, max in the lower half
  assign lo     = limits_i[2*LIMIT_W-1:LIMIT_W];
  assign hi     = limits_i[LIMIT_W-1:0];
  assign val_x  = CW'(value_i);
  assign lo_x   = CW'(lo);
  assign hi_x   = CW'(hi);
  // crossed limits never match
  assign in_win = (val_x >= lo_x) && (val_x <= hi_x);

  always_comb begin
    flags_o.or_used  = active_i && !and_mode_i && present_i;
    flags_o.or_miss  = active_i && !and_mode_i && !present_i;
    flags_o.or_hit   = active_i && !and_mode_i && present_i && in_win;
    flags_o.and_fail = active_i && and_mode_i && present_i && !in_win;
  end

endmodule : gcrf_lane
`default_nettype wire

### rtl/gcrf_run.sv
`default_nettype none
// -----------------------------------------------------------------------------
// gcrf_run
// Merges lane findings into the gate decision and tracks the held run.
// -----------------------------------------------------------------------------
module gcrf_run #(
  parameter int NUM_LANES = gcrf_pkg::HW_FIELDS,
  parameter int MAX_GATES = gcrf_pkg::MAX_GATES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               accept_i,
  input  wire gcrf_pkg::lane_flags_t              flags_i [NUM_LANES],
  input  wire logic                               last_i,
  input  wire logic                               enable_i,
  input  wire logic [gcrf_pkg::MIN_RUN_W-1:0]     min_run_i,
  output      gcrf_pkg::emit_t                    emit_o
);
  import gcrf_pkg::*;

  localparam int GIDX_W = $clog2(MAX_GATES);
  localparam int LEN_W  = $clog2(MAX_GATES + 1);
  localparam int CMP_W  = (LEN_W > MIN_RUN_W) ? LEN_W : MIN_RUN_W;

  logic [GIDX_W-1:0] gidx_q, gidx_d;
  logic [LEN_W-1:0]  plen_q, plen_d;
  logic [GIDX_W-1:0] pstart_q, pstart_d;

  logic              any_or_used, any_or_miss, any_or_hit, any_and_fail;
  logic              gate_cens;
  logic              flush_max;
  logic [LEN_W-1:0]  len_new;
  logic [GIDX_W-1:0] start_new;
  desc_t             held_d, tail_d, cens_d;

  // Merge stage: reduce lane flags
  always_comb begin
    any_or_used  = 1'b0;
    any_or_miss  = 1'b0;
    any_or_hit   = 1'b0;
    any_and_fail = 1'b0;
    for (int k = 0; k < NUM_LANES; k++) begin
      any_or_used  = any_or_used  | flags_i[k].or_used;
      any_or_miss  = any_or_miss  | flags_i[k].or_miss;
      any_or_hit   = any_or_hit   | flags_i[k].or_hit;
      any_and_fail = any_and_fail | flags_i[k].and_fail;
    end
    gate_cens = enable_i &&
                ((any_or_used && !any_or_miss && !any_or_hit) || any_and_fail);
  end

  // Resize to descriptor field widths
  function automatic logic [RUN_START_W-1:0] to_start(logic [GIDX_W-1:0] v);
    logic [GIDX_W+RUN_START_W-1:0] x;
    x = {{RUN_START_W{1'b0}}, v};
    return x[RUN_START_W-1:0];
  endfunction

  function automatic logic [RUN_LEN_W-1:0] to_len(logic [LEN_W-1:0] v);
    logic [LEN_W+RUN_LEN_W-1:0] x;
    x = {{RUN_LEN_W{1'b0}}, v};
    return x[RUN_LEN_W-1:0];
  endfunction

  // Short-run test with the current registers
  function automatic logic is_short(logic [LEN_W-1:0] len, logic en,
                                    logic [MIN_RUN_W-1:0] mvr);
    logic [CMP_W-1:0] l_x;
    logic [CMP_W-1:0] m_x;
    l_x = CMP_W'(len);
    m_x = CMP_W'(mvr);
    return en && (mvr > MIN_RUN_W'(1)) && (l_x < m_x);
  endfunction

  // Run bookkeeping and descriptor build
  always_comb begin
    flush_max = (plen_q == LEN_W'(MAX_GATES));
    start_new = ((plen_q == '0) || flush_max) ? gidx_q : pstart_q;
    len_new   = flush_max ? LEN_W'(1) : plen_q + LEN_W'(1);

    held_d.run_start  = to_start(pstart_q);
    held_d.run_length = to_len(plen_q);
    held_d.censored   = is_short(plen_q, enable_i, min_run_i);
    held_d.ray_end    = 1'b0;

    tail_d.run_start  = to_start(start_new);
    tail_d.run_length = to_len(len_new);
    tail_d.censored   = is_short(len_new, enable_i, min_run_i);
    tail_d.ray_end    = 1'b1;

    cens_d.run_start  = to_start(gidx_q);
    cens_d.run_length = RUN_LEN_W'(1);
    cens_d.censored   = 1'b1;
    cens_d.ray_end    = last_i;

    emit_o.push0 = 1'b0;
    emit_o.push1 = 1'b0;
    emit_o.d0    = held_d;
    emit_o.d1    = tail_d;
    plen_d       = plen_q;
    pstart_d     = pstart_q;
    gidx_d       = gidx_q;

    if (accept_i) begin
      if (gate_cens) begin
        plen_d = '0;
        if (plen_q != '0) begin
          emit_o.push0 = 1'b1;
          emit_o.push1 = 1'b1;
          emit_o.d1    = cens_d;
        end else begin
          emit_o.push0 = 1'b1;
          emit_o.d0    = cens_d;
        end
      end else begin
        plen_d   = len_new;
        pstart_d = start_new;
        if (flush_max) begin
          emit_o.push0 = 1'b1;
          emit_o.push1 = last_i;
        end else if (last_i) begin
          emit_o.push0 = 1'b1;
          emit_o.d0    = tail_d;
        end
      end
      // ray end clears the run state
      if (last_i) begin
        gidx_d   = '0;
        plen_d   = '0;
        pstart_d = '0;
      end else begin
        gidx_d = (gidx_q == GIDX_W'(MAX_GATES - 1)) ? '0 : gidx_q + GIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gidx_q   <= '0;
      plen_q   <= '0;
      pstart_q <= '0;
    end else begin
      gidx_q   <= gidx_d;
      plen_q   <= plen_d;
      pstart_q <= pstart_d;
    end
  end

endmodule : gcrf_run
`default_nettype wire

### rtl/gcrf_outq.sv
`default_nettype none
// -----------------------------------------------------------------------------
// gcrf_outq
// Small descriptor queue: up to two pushes and one pop per cycle.
// -----------------------------------------------------------------------------
module gcrf_outq (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire gcrf_pkg::emit_t         emit_i,
  output      logic                    space2_o,
  output      logic                    valid_o,
  input  wire logic                    ready_i,
  output      gcrf_pkg::desc_t         desc_o
);
  import gcrf_pkg::*;

  localparam int PTR_W = $clog2(OUTQ_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  desc_t             mem_q [OUTQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              pop;
  logic [PTR_W-1:0]  wr_ptr_p1;

  assign pop       = valid_o && ready_i;
  assign wr_ptr_p1 = wr_ptr_q + PTR_W'(1);
  assign valid_o   = (count_q != '0);
  assign desc_o    = mem_q[rd_ptr_q];
  // room for a full two-descriptor gate
  assign space2_o  = (count_q <= CNT_W'(OUTQ_DEPTH - 2));

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(emit_i.push0) + PTR_W'(emit_i.push1);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    count_d  = count_q + CNT_W'(emit_i.push0) + CNT_W'(emit_i.push1) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (emit_i.push0) begin
      mem_q[wr_ptr_q] <= emit_i.d0;
    end
    if (emit_i.push1) begin
      mem_q[wr_ptr_p1] <= emit_i.d1;
    end
  end

endmodule : gcrf_outq
`default_nettype wire

### rtl/gate_censor_run_filter_core.sv
`default_nettype none
// -----------------------------------------------------------------------------
// gate_censor_run_filter_core
// Censors radar range gates by field limits and emits run descriptors.
// -----------------------------------------------------------------------------
// Usage:
//   Slave stream: one range gate per transfer. tdata carries the test-field
//   values, tuser the presence mask, tlast marks the last gate of the ray.
//   Master stream: one run descriptor per transfer, with start and length in
//   tdata, the censored flag in tuser, and tlast on the ray's last descriptor.
//   Configuration: write cfg_data_i to register cfg_idx_i when cfg_we_i is
//   high; write only while the block is idle.
// Timing:
//   One gate per cycle while s_axis_tready is high. A gate yields zero, one
//   or two descriptors, registered into the four-entry output queue when the
//   gate is taken; the queue drains one per cycle while m_axis_tready is high,
//   so long stretches of two-descriptor gates run at the output rate.
//   s_axis_tready is high while the queue has room for two descriptors; it
//   does not depend on m_axis_tready in the same cycle.
// Reset:
//   Clears registers, gate index, held run and the queue.
// -----------------------------------------------------------------------------
module gate_censor_run_filter_core #(
  parameter int NUM_FIELDS  = gcrf_pkg::NUM_FIELDS_DEF,
  parameter int MAX_GATES   = gcrf_pkg::MAX_GATES_DEF,
  parameter int VALUE_WIDTH = gcrf_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  // value_0, value_1, value_2, value_3 (from bit 0 up), zero padded
  input  wire logic [((gcrf_pkg::HW_FIELDS*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // present_mask
  input  wire logic [gcrf_pkg::HW_FIELDS-1:0]               s_axis_tuser,
  input  wire logic                                         s_axis_tlast,
  input  wire logic                                         s_axis_tvalid,
  output      logic                                         s_axis_tready,
  // run_start, run_length (from bit 0 up), zero padded
  output      logic [gcrf_pkg::OUT_TDATA_W-1:0]             m_axis_tdata,
  // censored
  output      logic                                         m_axis_tuser,
  output      logic                                         m_axis_tlast,
  output      logic                                         m_axis_tvalid,
  input  wire logic                                         m_axis_tready,
  input  wire logic                                         cfg_we_i,
  input  wire logic [gcrf_pkg::CFG_IDX_W-1:0]               cfg_idx_i,
  input  wire logic [gcrf_pkg::CFG_DATA_W-1:0]              cfg_data_i
);
  import gcrf_pkg::*;

  localparam int NUM_LANES = (NUM_FIELDS < HW_FIELDS) ? NUM_FIELDS : HW_FIELDS;
  localparam int DESC_W    = RUN_START_W + RUN_LEN_W;

  logic [CFG_DATA_W-1:0] limits_q [HW_FIELDS];
  logic [HW_FIELDS-1:0]  and_mask_q;
  logic [HW_FIELDS-1:0]  act_mask_q;
  logic [MIN_RUN_W-1:0]  min_run_q;
  logic                  enable_q;

  lane_flags_t           flags [NUM_LANES];
  emit_t                 emit;
  desc_t                 desc;
  logic                  accept;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HW_FIELDS; k++) begin
        limits_q[k] <= '0;
      end
      and_mask_q <= '0;
      act_mask_q <= '0;
      min_run_q  <= '0;
      enable_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LIMITS_0, REG_LIMITS_1, REG_LIMITS_2, REG_LIMITS_3: begin
          limits_q[cfg_idx_i[1:0]] <= cfg_data_i;
        end
        REG_AND_MASK:  and_mask_q <= cfg_data_i[HW_FIELDS-1:0];
        REG_ACT_MASK:  act_mask_q <= cfg_data_i[HW_FIELDS-1:0];
        REG_MIN_RUN:   min_run_q  <= cfg_data_i[MIN_RUN_W-1:0];
        REG_CENSOR_EN: enable_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  // Field lanes
  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    gcrf_lane #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_lane (
      .value_i    (s_axis_tdata[k*VALUE_WIDTH +: VALUE_WIDTH]),
      .limits_i   (limits_q[k]),
      .active_i   (act_mask_q[k]),
      .and_mode_i (and_mask_q[k]),
      .present_i  (s_axis_tuser[k]),
      .flags_o    (flags[k])
    );
  end

  // Merge and run tracking
  gcrf_run #(
    .NUM_LANES (NUM_LANES),
    .MAX_GATES (MAX_GATES)
  ) u_run (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .flags_i   (flags),
    .last_i    (s_axis_tlast),
    .enable_i  (enable_q),
    .min_run_i (min_run_q),
    .emit_o    (emit)
  );

  // Output queue
  gcrf_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .emit_i   (emit),
    .space2_o (s_axis_tready),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .desc_o   (desc)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-DESC_W){1'b0}}, desc.run_length, desc.run_start};
  assign m_axis_tuser = desc.censored;
  assign m_axis_tlast = desc.ray_end;

endmodule : gate_censor_run_filter_core
`default_nettype wire

### rtl/gcrf_checker.sv
`default_nettype none
// -----------------------------------------------------------------------------
// gcrf_checker
// Port-level checks of the gate censor run filter, bound to the top level.
// -----------------------------------------------------------------------------
module gcrf_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  input  wire logic                             s_axis_tready,
  input  wire logic [gcrf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                             m_axis_tuser,
  input  wire logic                             m_axis_tlast,
  input  wire logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready
);
  import gcrf_pkg::*;

  // Stalled descriptor stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("descriptor dropped while stalled");

  // Stalled descriptor keeps its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("descriptor changed while stalled");

  // Every descriptor covers at least one gate
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[RUN_START_W +: RUN_LEN_W] != '0)
    else $error("zero-length run");

  // Empty output side means the input side can take a gate
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output queue");

  // A gate taken while the output queue is empty must afterwards leave a
  // descriptor offered or the input side ready
  a_accept_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> m_axis_tvalid || s_axis_tready)
    else $error("queue state inconsistent after accepted gate");

endmodule : gcrf_checker

bind gate_censor_run_filter_core gcrf_checker u_gcrf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
`default_nettype wire
